// ----- hw/rtl/xorshift_decrypt_crc_check_defines.svh -----
// Assertion macros shared by the RTL of the keystream decrypt / CRC check block.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef XORSHIFT_DECRYPT_CRC_CHECK_DEFINES_SVH
`define XORSHIFT_DECRYPT_CRC_CHECK_DEFINES_SVH

// Condition holds at every edge out of reset.
`define XDCC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define XDCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/xdcc_pkg.sv -----
// Types, constants and XOR-network functions for the keystream decrypt / CRC check block.
// No dependencies.
package xdcc_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES      = 32'hFFFFFFFF;
    localparam int          KS_SEED_STEPS = 9;
    localparam int          KS_SHIFT_A    = 13;
    localparam int          KS_SHIFT_B    = 17;
    localparam int          KS_SHIFT_C    = 5;
    localparam int          CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIPHER_KEY     = 3'd0,
        CFG_SEED_OFFSET    = 3'd1,
        CFG_DECRYPT_ENABLE = 3'd2,
        CFG_CHECK_ENABLE   = 3'd3,
        CFG_EXPECTED_CRC   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  plain_byte;
        logic        end_of_buffer;
        logic [31:0] crc_value;
        logic        crc_match;
    } out_item_t;

    typedef struct packed {
        logic [31:0] cipher_key;
        logic [31:0] seed_offset;
        logic        decrypt_enable;
        logic        check_enable;
        logic [31:0] expected_crc;
    } cfg_t;

    function automatic logic [31:0] ks_step(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w << KS_SHIFT_A);
        w = w ^ (w >> KS_SHIFT_B);
        w = w ^ (w << KS_SHIFT_C);
        return w;
    endfunction

    // Nine steps compose into one fixed 32x32 XOR matrix.
    function automatic logic [31:0] ks_seed(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        for (int k = 0; k < KS_SEED_STEPS; k++)
        begin
            w = ks_step(w);
        end
        return w;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/xdcc_core.sv -----
// Keystream and CRC state with the per-byte decrypt / CRC update.
// Depends on xdcc_pkg.
module xdcc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  xdcc_pkg::in_item_t  item,
    input  xdcc_pkg::cfg_t      cfg,
    output xdcc_pkg::out_item_t result
);
    import xdcc_pkg::*;

    logic [31:0] ks_word_reg, ks_word_next;
    logic [1:0]  lane_reg, lane_next;
    logic [31:0] crc_reg, crc_next;
    logic        started_reg, started_next;

    logic [31:0] ks_cur;
    logic [1:0]  lane_cur;
    logic [31:0] crc_cur;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [31:0] crc_fin;

    always_comb
    begin
        if (!started_reg)
        begin
            ks_cur   = ks_seed(cfg.cipher_key ^ cfg.seed_offset);
            lane_cur = 2'd0;
            crc_cur  = ALL_ONES;
        end
        else
        begin
            ks_cur   = ks_word_reg;
            lane_cur = lane_reg;
            crc_cur  = crc_reg;
        end

        key_byte = ks_cur[{lane_cur, 3'b000} +: 8];
        plain    = cfg.decrypt_enable ? (item.data_byte ^ key_byte) : item.data_byte;
        crc_next = crc_byte(crc_cur, plain);
        crc_fin  = ~crc_next;

        lane_next    = lane_cur + 2'd1;
        ks_word_next = (lane_cur == 2'd3) ? ks_step(ks_cur) : ks_cur;
        started_next = !item.last_byte;

        result.plain_byte    = plain;
        result.end_of_buffer = item.last_byte;
        result.crc_value     = item.last_byte ? crc_fin : 32'd0;
        result.crc_match     = item.last_byte
                               && (!cfg.check_enable || (crc_fin == cfg.expected_crc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_word_reg <= 32'd0;
            lane_reg    <= 2'd0;
            crc_reg     <= ALL_ONES;
            started_reg <= 1'b0;
        end
        else if (step)
        begin
            ks_word_reg <= ks_word_next;
            lane_reg    <= lane_next;
            crc_reg     <= crc_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- hw/rtl/xorshift_decrypt_crc_check.sv -----
// An accepted byte's result is registered in out_reg, or in skid_reg if out_reg is held.
// Throughput: one byte per cycle unless in_stall; keystream/CRC-32 step is one XOR network.
// A two-entry output (result register plus skid register) keeps in_stall registered.
// Reset: rst_n async low clears the config, keystream/lane/CRC state and both valid flags.
// Depends on xdcc_pkg, xdcc_core and the defines header.
`include "xorshift_decrypt_crc_check_defines.svh"

module xorshift_decrypt_crc_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  xdcc_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output xdcc_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xdcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import xdcc_pkg::*;

    cfg_t        cfg_reg;
    out_item_t   result;
    out_item_t   out_reg;
    out_item_t   skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_acc;
    logic        out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CIPHER_KEY:     cfg_reg.cipher_key     <= cfg_data;
                CFG_SEED_OFFSET:    cfg_reg.seed_offset    <= cfg_data;
                CFG_DECRYPT_ENABLE: cfg_reg.decrypt_enable <= cfg_data[0];
                CFG_CHECK_ENABLE:   cfg_reg.check_enable   <= cfg_data[0];
                CFG_EXPECTED_CRC:   cfg_reg.expected_crc   <= cfg_data;
                default:            ;
            endcase
        end
    end

    xdcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_acc),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg  <= skid_valid_reg || in_acc;
                skid_valid_reg <= 1'b0;
            end
            else if (in_acc)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (in_acc)
        begin
            skid_reg <= result;
        end
    end

    `XDCC_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid beat without output beat")
    `XDCC_ASSERT_NEXT(a_held_goes_to_skid, out_valid_reg && out_stall && in_acc, skid_valid_reg, "held output dropped new beat")
    `XDCC_ASSERT_ALWAYS(a_crc_only_at_end, !out_valid_reg || out_reg.end_of_buffer || (out_reg.crc_value == 32'd0 && !out_reg.crc_match), "CRC fields set on non-final beat")
    `XDCC_ASSERT_NEXT(a_accept_fills_out, in_acc, out_valid_reg, "accepted beat not presented")

endmodule
